// File: rtl/core/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  `ASSERT_CLK(lbl, clk, rst, !(expr))
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: rtl/core/dsdc_pkg.sv
// Types, constants, microcode and month table of the date and serial day converter.
package dsdc_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int SERIAL_W = 22;

  localparam int DEF_BASE_YEAR = 1800;
  localparam int DEF_LAST_YEAR = 9999;

  // Working year is one bit wider than the field so that year + 1 always fits.
  localparam int YW          = YEAR_W + 1;
  localparam int DBY_W       = 24;
  localparam int PC_W        = 5;
  localparam int BIT_IDX_W   = 4;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int DAYS_YEAR   = 365;
  localparam int DAYS_LEAP   = 366;
  localparam int MONTHS      = 12;
  localparam int LAST_MONTH_IDX = 11;

  typedef struct packed {
    logic                func;
    logic [YEAR_W-1:0]   year_in;
    logic [MONTH_W-1:0]  month_in;
    logic [DAY_W-1:0]    day_in;
    logic [SERIAL_W-1:0] serial_in;
  } dsdc_cmd_t;

  typedef struct packed {
    logic [SERIAL_W-1:0] serial_out;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic                range_error;
  } dsdc_rsp_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_LOAD,
    U_ENC_INIT,
    U_ADD_MONTH,
    U_OUT_ENC,
    U_OUT_ERR,
    U_BS_INIT,
    U_TRIAL_CHK,
    U_BS_DECIDE,
    U_SET_Y,
    U_DEC_INIT,
    U_SUB_MONTH,
    U_OUT_DEC
  } dsdc_uop_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_Y,
    SEL_Y1,
    SEL_TRIAL
  } dsdc_usel_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_CMD,
    C_FUNC1,
    C_YEAR_BAD,
    C_SERIAL_BAD,
    C_BIT_MORE,
    C_ENC_MDONE,
    C_DEC_MDONE,
    C_OUT_BLOCKED
  } dsdc_cond_t;

  typedef enum logic [PC_W-1:0] {
    S_IDLE,
    S_CHK_FUNC,
    S_CHK_YEAR,
    S_ENC_EVAL,
    S_ENC_NEXT,
    S_ENC_INIT,
    S_ENC_TEST,
    S_ENC_ADD,
    S_ENC_OUT,
    S_ERR_OUT,
    S_DEC_CHK,
    S_BS_INIT,
    S_BS_EVAL,
    S_BS_DECIDE,
    S_SET_Y,
    S_DEC_EVAL,
    S_DEC_NEXT,
    S_DEC_INIT,
    S_DEC_TEST,
    S_DEC_SUB,
    S_DEC_OUT
  } dsdc_step_t;

  typedef struct packed {
    dsdc_usel_t usel;
    logic       cap;
    dsdc_uop_t  op;
    dsdc_cond_t cond;
    dsdc_step_t target;
    logic       last;
  } dsdc_cw_t;

  typedef struct packed {
    logic no_cmd;
    logic func1;
    logic year_bad;
    logic serial_bad;
    logic bit_more;
    logic enc_mdone;
    logic dec_mdone;
    logic out_blocked;
  } dsdc_status_t;

  // Control store. A taken condition jumps to target; otherwise the step falls
  // through, or returns to idle when it is the last step of a routine.
  function automatic dsdc_cw_t ucode(input logic [PC_W-1:0] pc);
    dsdc_cw_t cw;
    cw = '{usel: SEL_NONE, cap: 1'b0, op: U_NOP, cond: C_NEVER, target: S_IDLE,
           last: 1'b0};
    unique case (pc)
      S_IDLE: begin
        cw.op = U_LOAD;      cw.cond = C_NO_CMD;      cw.target = S_IDLE;
      end
      S_CHK_FUNC: begin
        cw.cond = C_FUNC1;   cw.target = S_DEC_CHK;
      end
      S_CHK_YEAR: begin
        cw.cond = C_YEAR_BAD; cw.target = S_ERR_OUT;
      end
      S_ENC_EVAL: begin
        cw.usel = SEL_Y;
      end
      S_ENC_NEXT: begin
        cw.usel = SEL_Y1;    cw.cap = 1'b1;
      end
      S_ENC_INIT: begin
        cw.op = U_ENC_INIT;
      end
      S_ENC_TEST: begin
        cw.cond = C_ENC_MDONE; cw.target = S_ENC_OUT;
      end
      S_ENC_ADD: begin
        cw.op = U_ADD_MONTH; cw.cond = C_ALWAYS;      cw.target = S_ENC_TEST;
      end
      S_ENC_OUT: begin
        cw.op = U_OUT_ENC;   cw.cond = C_OUT_BLOCKED; cw.target = S_ENC_OUT;
        cw.last = 1'b1;
      end
      S_ERR_OUT: begin
        cw.op = U_OUT_ERR;   cw.cond = C_OUT_BLOCKED; cw.target = S_ERR_OUT;
        cw.last = 1'b1;
      end
      S_DEC_CHK: begin
        cw.cond = C_SERIAL_BAD; cw.target = S_ERR_OUT;
      end
      S_BS_INIT: begin
        cw.op = U_BS_INIT;
      end
      S_BS_EVAL: begin
        cw.usel = SEL_TRIAL; cw.op = U_TRIAL_CHK;
      end
      S_BS_DECIDE: begin
        cw.op = U_BS_DECIDE; cw.cond = C_BIT_MORE;    cw.target = S_BS_EVAL;
      end
      S_SET_Y: begin
        cw.op = U_SET_Y;
      end
      S_DEC_EVAL: begin
        cw.usel = SEL_Y;
      end
      S_DEC_NEXT: begin
        cw.usel = SEL_Y1;    cw.cap = 1'b1;
      end
      S_DEC_INIT: begin
        cw.op = U_DEC_INIT;
      end
      S_DEC_TEST: begin
        cw.cond = C_DEC_MDONE; cw.target = S_DEC_OUT;
      end
      S_DEC_SUB: begin
        cw.op = U_SUB_MONTH; cw.cond = C_ALWAYS;      cw.target = S_DEC_TEST;
      end
      S_DEC_OUT: begin
        cw.op = U_OUT_DEC;   cw.cond = C_OUT_BLOCKED; cw.target = S_DEC_OUT;
        cw.last = 1'b1;
      end
      default: begin
        cw.cond = C_ALWAYS;  cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

  // Length of month index mi (0 is January) in a leap or common year.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mi,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (mi)
      4'd1:                      n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/dsdc_useq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module dsdc_useq (
  input  logic                  clk,
  input  logic                  rst,
  input  dsdc_pkg::dsdc_status_t status,
  output dsdc_pkg::dsdc_cw_t     cw
);

  logic [dsdc_pkg::PC_W-1:0] pc;
  logic [dsdc_pkg::PC_W-1:0] pc_next;
  logic                      hit;

  assign cw = dsdc_pkg::ucode(pc);

  always_comb begin
    unique case (cw.cond)
      dsdc_pkg::C_NEVER:       hit = 1'b0;
      dsdc_pkg::C_ALWAYS:      hit = 1'b1;
      dsdc_pkg::C_NO_CMD:      hit = status.no_cmd;
      dsdc_pkg::C_FUNC1:       hit = status.func1;
      dsdc_pkg::C_YEAR_BAD:    hit = status.year_bad;
      dsdc_pkg::C_SERIAL_BAD:  hit = status.serial_bad;
      dsdc_pkg::C_BIT_MORE:    hit = status.bit_more;
      dsdc_pkg::C_ENC_MDONE:   hit = status.enc_mdone;
      dsdc_pkg::C_DEC_MDONE:   hit = status.dec_mdone;
      dsdc_pkg::C_OUT_BLOCKED: hit = status.out_blocked;
      default:                 hit = 1'b0;
    endcase
  end

  always_comb begin
    if (hit) begin
      pc_next = cw.target;
    end else if (cw.last) begin
      pc_next = dsdc_pkg::S_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dsdc_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/core/dsdc_year_unit.sv
// Days from 1 January of the base year to 1 January of year x, in two steps.
module dsdc_year_unit #(
  parameter int BASE_YEAR = dsdc_pkg::DEF_BASE_YEAR
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [dsdc_pkg::YW-1:0]    x,
  output logic [dsdc_pkg::DBY_W-1:0] dby
);

  localparam int YW     = dsdc_pkg::YW;
  localparam int DBY_W  = dsdc_pkg::DBY_W;
  localparam int Q4_W   = YW - 2;
  // Quotients of a 14-bit year by 100 and by 400 stay below 164 and 41.
  localparam int Q100_W = 8;
  localparam int Q400_W = 6;
  localparam int PROD_W = YW + 13;
  localparam int LEAPS_BEFORE = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                              + (BASE_YEAR - 1) / 400;

  logic [YW-1:0]     xm1;
  logic [YW-1:0]     span;
  logic [Q4_W-1:0]   q4_c;
  logic [PROD_W-1:0] p100;
  logic [PROD_W-1:0] p400;

  logic [Q4_W-1:0]   q4;
  logic [Q100_W-1:0] q100;
  logic [Q400_W-1:0] q400;
  logic [DBY_W-1:0]  m365;

  assign xm1  = x - 1'b1;
  assign span = x - YW'(BASE_YEAR);
  assign q4_c = xm1[YW-1:2];
  // Division by 100 as a reciprocal multiply; exact for every 15-bit operand used.
  assign p100 = PROD_W'(xm1) * PROD_W'(dsdc_pkg::RECIP_100);
  assign p400 = PROD_W'(q4_c) * PROD_W'(dsdc_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (en) begin
      q4   <= q4_c;
      q100 <= p100[dsdc_pkg::RECIP_SHIFT +: Q100_W];
      q400 <= p400[dsdc_pkg::RECIP_SHIFT +: Q400_W];
      m365 <= DBY_W'(span) * DBY_W'(dsdc_pkg::DAYS_YEAR);
    end
  end

  assign dby = m365 + DBY_W'(q4) - DBY_W'(q100) + DBY_W'(q400) - DBY_W'(LEAPS_BEFORE);

endmodule

// File: rtl/core/dsdc_datapath.sv
// Datapath of the converter: working registers, year unit, month walk, result register.
module dsdc_datapath #(
  parameter int BASE_YEAR = dsdc_pkg::DEF_BASE_YEAR,
  parameter int LAST_YEAR = dsdc_pkg::DEF_LAST_YEAR
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dsdc_pkg::dsdc_cw_t     cw,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  dsdc_pkg::dsdc_cmd_t    cmd,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output dsdc_pkg::dsdc_rsp_t    rsp,
  output dsdc_pkg::dsdc_status_t status
);

  localparam int YW      = dsdc_pkg::YW;
  localparam int DBY_W   = dsdc_pkg::DBY_W;
  localparam int MONTH_W = dsdc_pkg::MONTH_W;
  localparam int SPAN    = LAST_YEAR - BASE_YEAR;
  localparam int KW      = $clog2(SPAN + 1);
  localparam int MAX_SERIAL = dsdc_pkg::DAYS_YEAR * (SPAN + 1)
                            + (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400)
                            - ((BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                               + (BASE_YEAR - 1) / 400);

  logic                            func_r;
  logic [YW-1:0]                   y;
  logic [MONTH_W-1:0]              month_lim;
  logic [dsdc_pkg::DAY_W-1:0]      day_r;
  logic [dsdc_pkg::SERIAL_W-1:0]   serial_r;
  logic [KW-1:0]                   k;
  logic [dsdc_pkg::BIT_IDX_W-1:0]  bit_idx;
  logic                            trial_ok;
  logic [DBY_W-1:0]                dby_a;
  logic [DBY_W-1:0]                acc;
  logic                            leap;
  logic [MONTH_W-1:0]              mi;

  logic [KW-1:0]                   trial;
  logic [YW-1:0]                   trial_year;
  logic [YW-1:0]                   unit_x;
  logic                            unit_en;
  logic [DBY_W-1:0]                dby;
  logic [dsdc_pkg::DAY_W-1:0]      dim;
  logic                            out_op;
  logic                            out_load;
  dsdc_pkg::dsdc_rsp_t             rsp_next;

  assign trial      = k | (KW'(1) << bit_idx);
  assign trial_year = YW'(BASE_YEAR) + YW'(trial);
  assign dim        = dsdc_pkg::month_days(mi, leap);

  always_comb begin
    case (cw.usel)
      dsdc_pkg::SEL_Y1:    unit_x = y + 1'b1;
      dsdc_pkg::SEL_TRIAL: unit_x = trial_year;
      default:             unit_x = y;
    endcase
  end

  assign unit_en = (cw.usel != dsdc_pkg::SEL_NONE);

  dsdc_year_unit #(
    .BASE_YEAR (BASE_YEAR)
  ) u_year (
    .clk (clk),
    .en  (unit_en),
    .x   (unit_x),
    .dby (dby)
  );

  assign cmd_ready = (cw.op == dsdc_pkg::U_LOAD);

  assign status.no_cmd      = !cmd_valid;
  assign status.func1       = func_r;
  assign status.year_bad    = (y < YW'(BASE_YEAR)) || (y > YW'(LAST_YEAR));
  assign status.serial_bad  = DBY_W'(serial_r) > DBY_W'(MAX_SERIAL);
  assign status.bit_more    = (bit_idx != '0);
  assign status.enc_mdone   = ({1'b0, mi} + 5'd1) >= {1'b0, month_lim};
  assign status.dec_mdone   = (mi == MONTH_W'(dsdc_pkg::LAST_MONTH_IDX))
                           || (acc <= DBY_W'(dim));
  assign status.out_blocked = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (cw.cap) begin
      dby_a <= dby;
    end
    unique case (cw.op)
      dsdc_pkg::U_LOAD: begin
        if (cmd_valid) begin
          func_r    <= cmd.func;
          y         <= {1'b0, cmd.year_in};
          month_lim <= (cmd.month_in > MONTH_W'(dsdc_pkg::MONTHS))
                       ? MONTH_W'(dsdc_pkg::MONTHS) : cmd.month_in;
          day_r     <= cmd.day_in;
          serial_r  <= cmd.serial_in;
        end
      end
      dsdc_pkg::U_ENC_INIT: begin
        leap <= (dby - dby_a) == DBY_W'(dsdc_pkg::DAYS_LEAP);
        acc  <= dby_a + DBY_W'(day_r);
        mi   <= '0;
      end
      dsdc_pkg::U_ADD_MONTH: begin
        acc <= acc + DBY_W'(dim);
        mi  <= mi + 1'b1;
      end
      dsdc_pkg::U_BS_INIT: begin
        k       <= '0;
        bit_idx <= dsdc_pkg::BIT_IDX_W'(KW - 1);
      end
      dsdc_pkg::U_TRIAL_CHK: begin
        trial_ok <= trial_year <= YW'(LAST_YEAR);
      end
      dsdc_pkg::U_BS_DECIDE: begin
        // Keep the bit when that year still starts on or before the serial day.
        if (trial_ok && (dby < DBY_W'(serial_r))) begin
          k <= trial;
        end
        bit_idx <= bit_idx - 1'b1;
      end
      dsdc_pkg::U_SET_Y: begin
        y <= YW'(BASE_YEAR) + YW'(k);
      end
      dsdc_pkg::U_DEC_INIT: begin
        leap <= (dby - dby_a) == DBY_W'(dsdc_pkg::DAYS_LEAP);
        acc  <= DBY_W'(serial_r) - dby_a;
        mi   <= '0;
      end
      dsdc_pkg::U_SUB_MONTH: begin
        acc <= acc - DBY_W'(dim);
        mi  <= mi + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_op   = (cw.op == dsdc_pkg::U_OUT_ENC) || (cw.op == dsdc_pkg::U_OUT_DEC)
                 || (cw.op == dsdc_pkg::U_OUT_ERR);
  assign out_load = out_op && !status.out_blocked;

  always_comb begin
    rsp_next = '0;
    case (cw.op)
      dsdc_pkg::U_OUT_ENC: begin
        rsp_next.serial_out = acc[dsdc_pkg::SERIAL_W-1:0];
      end
      dsdc_pkg::U_OUT_DEC: begin
        rsp_next.year_out  = y[dsdc_pkg::YEAR_W-1:0];
        rsp_next.month_out = mi + 1'b1;
        rsp_next.day_out   = acc[dsdc_pkg::DAY_W-1:0];
      end
      dsdc_pkg::U_OUT_ERR: begin
        rsp_next.range_error = 1'b1;
        if (func_r) begin
          rsp_next.year_out  = dsdc_pkg::YEAR_W'(BASE_YEAR);
          rsp_next.month_out = MONTH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/date_serial_day_converter_core.sv
// Top level of the Gregorian date and serial day number converter.
//
//   channel  direction  handshake              payload
//   cmd      in         cmd_valid / cmd_ready  dsdc_cmd_t: func, date, serial
//   rsp      out        rsp_valid / rsp_ready  dsdc_rsp_t: serial, date, range_error
//
// One transaction at a time. Date to serial walks the months before the given one (at
// most 11); serial to date runs a year bisection over the KW bits of the year span, each
// bit tried in an evaluate step and a decide step, then walks the whole months passed
// (at most 11). Range errors go from the year or serial check to the error output step.
// The next transaction is accepted in the cycle after the output step at the earliest.
// Reset is synchronous and clears the step counter and rsp_valid. A stalled rsp holds
// only the final step; cmd_ready returns once the result sits in the output register.
`include "assert_macros.svh"

module date_serial_day_converter_core #(
  parameter int BASE_YEAR = dsdc_pkg::DEF_BASE_YEAR,
  parameter int LAST_YEAR = dsdc_pkg::DEF_LAST_YEAR
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  dsdc_pkg::dsdc_cmd_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output dsdc_pkg::dsdc_rsp_t rsp
);

  dsdc_pkg::dsdc_cw_t     cw;
  dsdc_pkg::dsdc_status_t status;
  logic                   out_step;
  logic                   year_ok;

  dsdc_useq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw)
  );

  dsdc_datapath #(
    .BASE_YEAR (BASE_YEAR),
    .LAST_YEAR (LAST_YEAR)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cw        (cw),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .status    (status)
  );

  assign out_step = (cw.op == dsdc_pkg::U_OUT_ENC) || (cw.op == dsdc_pkg::U_OUT_DEC)
                 || (cw.op == dsdc_pkg::U_OUT_ERR);
  assign year_ok  = (rsp.year_out >= dsdc_pkg::YEAR_W'(BASE_YEAR))
                 && (rsp.year_out <= dsdc_pkg::YEAR_W'(LAST_YEAR));

  // An accepted transaction keeps the block busy in the following cycle.
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (cmd_valid && cmd_ready) |=> !cmd_ready)
  // A new result only appears after one of the output steps.
  `ASSERT_CLK(a_rsp_from_out_step, clk, rst, $rose(rsp_valid) |-> $past(out_step))
  // A decoded year lies inside the supported span.
  `ASSERT_CLK(a_year_in_span, clk, rst, (rsp_valid && rsp.year_out != '0) |-> year_ok)
  `ASSERT_NEVER(a_month_in_range, clk, rst, rsp_valid && rsp.month_out > 4'(dsdc_pkg::MONTHS))

endmodule

// File: tb/date_serial_day_converter_core_test.sv
// Self-checking testbench for the date and serial day number converter core.
module date_serial_day_converter_core_test;

  localparam int YEAR_LO = dsdc_pkg::DEF_BASE_YEAR;
  localparam int YEAR_HI = dsdc_pkg::DEF_LAST_YEAR;
  localparam int YEAR_W = dsdc_pkg::YEAR_W;
  localparam int MONTH_W = dsdc_pkg::MONTH_W;
  localparam int DAY_W = dsdc_pkg::DAY_W;
  localparam int SERIAL_W = dsdc_pkg::SERIAL_W;
  localparam int MONTHS = dsdc_pkg::MONTHS;
  localparam int LAST_MONTH_IDX = dsdc_pkg::LAST_MONTH_IDX;
  localparam int DAYS_400_YEARS = 146097;
  localparam int RANDOM_PER_PHASE = 410;
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int TIMEOUT_CYCLES = 1500000;

  localparam logic FUNC_TO_SERIAL = 1'b0;
  localparam logic FUNC_TO_DATE   = 1'b1;
  localparam logic IN_RANGE       = 1'b0;
  localparam logic OUT_OF_RANGE   = 1'b1;

  typedef struct {
    dsdc_pkg::dsdc_cmd_t cmd;
    bit                  known;
    dsdc_pkg::dsdc_rsp_t rsp;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_ready;
  dsdc_pkg::dsdc_cmd_t cmd;
  logic                rsp_valid;
  logic                rsp_ready;
  dsdc_pkg::dsdc_rsp_t rsp;

  dsdc_pkg::dsdc_rsp_t awaited_rsp[$];
  int                  cmd_idle_pct;
  int                  rsp_idle_pct;
  bit                  rsp_hold_req;
  int                  n_fail;
  int                  n_answers;
  int                  n_to_serial;
  int                  n_to_date;
  int                  n_range_err;

  date_serial_day_converter_core #(
    .BASE_YEAR(YEAR_LO),
    .LAST_YEAR(YEAR_HI)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned leaps_upto(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Days in the whole years from the first supported year up to y - 1.
  function automatic int unsigned days_before(int unsigned y);
    return 365 * (y - YEAR_LO) + leaps_upto(y - 1) - leaps_upto(YEAR_LO - 1);
  endfunction

  function automatic int unsigned month_length(int unsigned mi, int unsigned y);
    if (mi == 1) begin
      return leap_year(y) ? 29 : 28;
    end
    if (mi == 3 || mi == 5 || mi == 8 || mi == 10) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic dsdc_pkg::dsdc_rsp_t calendar_convert(dsdc_pkg::dsdc_cmd_t c);
    dsdc_pkg::dsdc_rsp_t r;
    int unsigned         acc;
    int unsigned         mon;
    int unsigned         mi;
    int unsigned         y;
    int unsigned         rem;
    r = '0;
    if (c.func == FUNC_TO_SERIAL) begin
      if (c.year_in < YEAR_LO || c.year_in > YEAR_HI) begin
        r.range_error = OUT_OF_RANGE;
      end else begin
        acc = c.day_in;
        mon = (c.month_in > MONTHS) ? MONTHS : c.month_in;
        for (mi = 0; mi + 1 < mon; mi++) begin
          acc += month_length(mi, c.year_in);
        end
        acc += days_before(c.year_in);
        r.serial_out = SERIAL_W'(acc);
      end
    end else begin
      r.year_out = YEAR_W'(YEAR_LO);
      r.month_out = MONTH_W'(1);
      if (c.serial_in > days_before(YEAR_HI + 1)) begin
        r.range_error = OUT_OF_RANGE;
      end else begin
        rem = c.serial_in;
        y = YEAR_LO;
        // Any 400 consecutive Gregorian years hold the same number of days.
        while (rem > DAYS_400_YEARS) begin
          rem -= DAYS_400_YEARS;
          y += 400;
        end
        while (rem > (leap_year(y) ? 366 : 365)) begin
          rem -= leap_year(y) ? 366 : 365;
          y++;
        end
        mi = 0;
        while (mi < LAST_MONTH_IDX && rem > month_length(mi, y)) begin
          rem -= month_length(mi, y);
          mi++;
        end
        r.year_out = YEAR_W'(y);
        r.month_out = MONTH_W'(mi + 1);
        r.day_out = DAY_W'(rem);
      end
    end
    return r;
  endfunction

  function automatic dsdc_pkg::dsdc_rsp_t answer(int s, int y, int m, int d, logic err);
    dsdc_pkg::dsdc_rsp_t r;
    r.serial_out = SERIAL_W'(s);
    r.year_out = YEAR_W'(y);
    r.month_out = MONTH_W'(m);
    r.day_out = DAY_W'(d);
    r.range_error = err;
    return r;
  endfunction

  // Fields that the chosen direction ignores carry random values.
  function automatic dir_row_t date_row(int y, int m, int d, bit known = 1'b0,
                                        dsdc_pkg::dsdc_rsp_t rsp = '0);
    dir_row_t row;
    row.cmd.func = FUNC_TO_SERIAL;
    row.cmd.year_in = YEAR_W'(y);
    row.cmd.month_in = MONTH_W'(m);
    row.cmd.day_in = DAY_W'(d);
    row.cmd.serial_in = SERIAL_W'($urandom);
    row.known = known;
    row.rsp = rsp;
    return row;
  endfunction

  function automatic dir_row_t serial_row(int s, bit known = 1'b0,
                                          dsdc_pkg::dsdc_rsp_t rsp = '0);
    dir_row_t row;
    row.cmd.func = FUNC_TO_DATE;
    row.cmd.year_in = YEAR_W'($urandom);
    row.cmd.month_in = MONTH_W'($urandom);
    row.cmd.day_in = DAY_W'($urandom);
    row.cmd.serial_in = SERIAL_W'(s);
    row.known = known;
    row.rsp = rsp;
    return row;
  endfunction

  // Mostly valid dates and serials, with out-of-range years and serials mixed in.
  function automatic dsdc_pkg::dsdc_cmd_t random_request();
    dsdc_pkg::dsdc_cmd_t c;
    int                  pick;
    c.func = FUNC_TO_SERIAL;
    c.year_in = YEAR_W'($urandom);
    c.month_in = MONTH_W'($urandom);
    c.day_in = DAY_W'($urandom);
    c.serial_in = SERIAL_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      c.year_in = YEAR_W'($urandom_range(YEAR_HI, YEAR_LO));
      if ($urandom_range(9) != 0) begin
        c.month_in = MONTH_W'($urandom_range(MONTHS, 1));
      end
    end else if (pick < 55) begin
      c.year_in = YEAR_W'($urandom_range((1 << YEAR_W) - 1, 0));
    end else if (pick < 80) begin
      c.func = FUNC_TO_DATE;
      c.serial_in = SERIAL_W'($urandom_range(days_before(YEAR_HI + 1), 0));
    end else if (pick < 92) begin
      // Land on the last or first day of some year.
      c.func = FUNC_TO_DATE;
      c.serial_in = SERIAL_W'(days_before($urandom_range(YEAR_HI, YEAR_LO))
                              + $urandom_range(1, 0));
    end else begin
      c.func = FUNC_TO_DATE;
      c.serial_in = SERIAL_W'($urandom_range((1 << SERIAL_W) - 1, 0));
    end
    return c;
  endfunction

  task automatic send_request(input dsdc_pkg::dsdc_cmd_t c, input dsdc_pkg::dsdc_rsp_t want);
    while ($urandom_range(99) < cmd_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) begin
      @(posedge clk);
    end
    awaited_rsp.push_back(want);
    if (c.func == FUNC_TO_SERIAL) begin
      n_to_serial++;
    end else begin
      n_to_date++;
    end
    if (want.range_error == OUT_OF_RANGE) begin
      n_range_err++;
    end
  endtask

  task automatic check_answer(input dsdc_pkg::dsdc_rsp_t got);
    dsdc_pkg::dsdc_rsp_t want;
    n_answers++;
    if (awaited_rsp.size() == 0) begin
      $error("response with no transaction outstanding: %p", got);
      n_fail++;
    end else begin
      want = awaited_rsp.pop_front();
      if (got.serial_out !== want.serial_out) begin
        $error("serial_out: expected %0d, got %0d", want.serial_out, got.serial_out);
        n_fail++;
      end
      if (got.year_out !== want.year_out) begin
        $error("year_out: expected %0d, got %0d", want.year_out, got.year_out);
        n_fail++;
      end
      if (got.month_out !== want.month_out) begin
        $error("month_out: expected %0d, got %0d", want.month_out, got.month_out);
        n_fail++;
      end
      if (got.day_out !== want.day_out) begin
        $error("day_out: expected %0d, got %0d", want.day_out, got.day_out);
        n_fail++;
      end
      if (got.range_error !== want.range_error) begin
        $error("range_error: expected %0d, got %0d", want.range_error, got.range_error);
        n_fail++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("** date_serial_day_converter_core: FAILED **");
    $finish;
  end

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        repeat (RSP_HOLD_CYCLES) begin
          rsp_ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        check_answer(rsp);
      end
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    int       k;
    n_fail = 0;
    n_answers = 0;
    n_to_serial = 0;
    n_to_date = 0;
    n_range_err = 0;
    rsp_hold_req = 1'b0;
    cmd_idle_pct = 8;
    rsp_idle_pct = 60;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;

    dir_rows.push_back(date_row(YEAR_LO, 1, 1, 1'b1, answer(1, 0, 0, 0, IN_RANGE)));
    // Month zero counts as January, so day zero lands on serial zero.
    dir_rows.push_back(date_row(YEAR_LO, 0, 0, 1'b1, answer(0, 0, 0, 0, IN_RANGE)));
    dir_rows.push_back(date_row(YEAR_HI, 12, 31, 1'b1,
                                answer(2994988, 0, 0, 0, IN_RANGE)));
    dir_rows.push_back(date_row(YEAR_LO - 1, 5, 5, 1'b1, answer(0, 0, 0, 0, OUT_OF_RANGE)));
    dir_rows.push_back(date_row(YEAR_HI + 1, 1, 1, 1'b1, answer(0, 0, 0, 0, OUT_OF_RANGE)));
    dir_rows.push_back(date_row(0, 1, 1, 1'b1, answer(0, 0, 0, 0, OUT_OF_RANGE)));
    dir_rows.push_back(date_row((1 << YEAR_W) - 1, 15, 31, 1'b1,
                                answer(0, 0, 0, 0, OUT_OF_RANGE)));
    dir_rows.push_back(date_row(2000, 2, 29));
    dir_rows.push_back(date_row(1900, 3, 1));
    dir_rows.push_back(date_row(2024, 15, 31));
    dir_rows.push_back(date_row(2023, 2, 31));
    dir_rows.push_back(date_row(1801, 0, 31));
    dir_rows.push_back(date_row(YEAR_HI, 13, 0));
    dir_rows.push_back(serial_row(0, 1'b1, answer(0, YEAR_LO, 1, 0, IN_RANGE)));
    dir_rows.push_back(serial_row(1, 1'b1, answer(0, YEAR_LO, 1, 1, IN_RANGE)));
    dir_rows.push_back(serial_row(2994988, 1'b1, answer(0, YEAR_HI, 12, 31, IN_RANGE)));
    dir_rows.push_back(serial_row(2994989, 1'b1, answer(0, YEAR_LO, 1, 0, OUT_OF_RANGE)));
    dir_rows.push_back(serial_row((1 << SERIAL_W) - 1, 1'b1,
                                  answer(0, YEAR_LO, 1, 0, OUT_OF_RANGE)));
    dir_rows.push_back(serial_row(365));
    dir_rows.push_back(serial_row(366));
    dir_rows.push_back(serial_row(days_before(2000) + 60));
    dir_rows.push_back(serial_row(days_before(1900) + 59));
    dir_rows.push_back(serial_row(days_before(YEAR_HI) + 1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].cmd,
                   dir_rows[i].known ? dir_rows[i].rsp : calendar_convert(dir_rows[i].cmd));
    end

    for (k = 0; k < 3 * RANDOM_PER_PHASE; k++) begin
      if (k == RANDOM_PER_PHASE) begin
        cmd_idle_pct = 60;
        rsp_idle_pct = 8;
      end else if (k == 2 * RANDOM_PER_PHASE) begin
        cmd_idle_pct = 0;
        rsp_idle_pct = 0;
        // The sender keeps offering while responses are held off.
        rsp_hold_req = 1'b1;
      end
      begin
        dsdc_pkg::dsdc_cmd_t c;
        c = random_request();
        send_request(c, calendar_convert(c));
      end
    end
    cmd_valid <= 1'b0;

    while (awaited_rsp.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d date-to-serial and %0d serial-to-date transactions, %0d of them",
             n_to_serial, n_to_date, n_range_err);
    $display("out of range, under three back-pressure mixes and one long response stall.");
    if (n_fail == 0) begin
      $display("** date_serial_day_converter_core: PASSED **");
    end else begin
      $display("** date_serial_day_converter_core: FAILED **");
    end
    $finish;
  end

endmodule
